>>> rtl/core/assert_macros.svh
// Assertion helpers; bodies vanish when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_IMPL(lbl, clk, rst, a, b) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("assertion failed: same-cycle implication");
`define ASSERT_NEXT(lbl, clk, rst, a, b) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("assertion failed: next-cycle implication");
`else
`define ASSERT_IMPL(lbl, clk, rst, a, b)
`define ASSERT_NEXT(lbl, clk, rst, a, b)
`endif

`endif

>>> rtl/core/i2cm_pkg.sv
package i2cm_pkg;

  typedef struct packed {
    logic       cmd_start;
    logic       opcode;
    logic [7:0] slave_addr;
    logic [7:0] reg_addr;
    logic [7:0] byte_count;
    logic [7:0] wr_data;
    logic       sda_in;
  } in_t;

  typedef struct packed {
    logic       scl;
    logic       sda;
    logic       take_data;
    logic [7:0] rd_data;
    logic       rd_valid;
    logic       busy_res;
    logic       done_res;
    logic       nack;
  } out_t;

  // queue entry: raw tick plus what the front works out ahead of time
  typedef struct packed {
    in_t        item;
    logic       is_cmd;
    logic [7:0] slave_inc;
  } entry_t;

  typedef struct packed {
    logic q_valid;
    logic q_full;
  } q_status_t;

  typedef enum logic [13:0] {
    ST_IDLE      = 14'b00000000000001,
    ST_START     = 14'b00000000000010,
    ST_SLAVE     = 14'b00000000000100,
    ST_ACK_SLAVE = 14'b00000000001000,
    ST_REG       = 14'b00000000010000,
    ST_ACK_REG   = 14'b00000000100000,
    ST_RESTART   = 14'b00000001000000,
    ST_SLAVE_RD  = 14'b00000010000000,
    ST_ACK_RD    = 14'b00000100000000,
    ST_DATA      = 14'b00001000000000,
    ST_ACK_DATA  = 14'b00010000000000,
    ST_READ      = 14'b00100000000000,
    ST_MACK      = 14'b01000000000000,
    ST_STOP      = 14'b10000000000000
  } stage_t;

  // register index, taken from paddr[2]
  localparam logic REG_ABORT_ON_NACK = 1'b0;

endpackage

>>> rtl/core/i2cm_front.sv
module i2cm_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  i2cm_pkg::in_t       in_item,
  input  logic                pop,
  output i2cm_pkg::entry_t    q_head,
  output i2cm_pkg::q_status_t q_status
);

  i2cm_pkg::entry_t slot0;
  i2cm_pkg::entry_t slot1;
  i2cm_pkg::entry_t push_entry;
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;
  logic             push;

  assign in_stall = (count == 2'd2);
  assign push     = in_valid && !in_stall;

  always_comb begin
    push_entry.item      = in_item;
    push_entry.is_cmd    = in_item.cmd_start;
    push_entry.slave_inc = in_item.slave_addr + 8'd1;
  end

  always_ff @(posedge clk) begin
    if (push && !wr_ptr) begin
      slot0 <= push_entry;
    end
    if (push && wr_ptr) begin
      slot1 <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  assign q_head           = rd_ptr ? slot1 : slot0;
  assign q_status.q_valid = (count != 2'd0);
  assign q_status.q_full  = in_stall;

endmodule

>>> rtl/core/i2cm_back.sv
module i2cm_back #(
  parameter int COUNT_BITS = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             abort_on_nack,
  input  logic             pop,
  input  i2cm_pkg::entry_t entry,
  output logic             out_valid,
  input  logic             out_stall,
  output i2cm_pkg::out_t   out_item
);

  i2cm_pkg::stage_t      stage, stage_next;
  logic [1:0]            phase, phase_next;
  logic [2:0]            bit_index, bit_index_next;
  logic [7:0]            shift_byte, shift_byte_next;
  logic [COUNT_BITS-1:0] bytes_left, bytes_left_next;
  logic [7:0]            saved_slave, saved_slave_next;
  logic [7:0]            saved_slave_inc, saved_slave_inc_next;
  logic [7:0]            saved_reg, saved_reg_next;
  logic                  is_read, is_read_next;
  logic                  ack_seen, ack_seen_next;
  logic [1:0]            line_levels;
  logic [7:0]            shift_sel;
  logic [COUNT_BITS-1:0] count_dec;
  i2cm_pkg::out_t        res;

  assign count_dec = bytes_left - COUNT_BITS'(1);

  always_comb begin
    stage_next           = stage;
    phase_next           = phase;
    bit_index_next       = bit_index;
    shift_byte_next      = shift_byte;
    bytes_left_next      = bytes_left;
    saved_slave_next     = saved_slave;
    saved_slave_inc_next = saved_slave_inc;
    saved_reg_next       = saved_reg;
    is_read_next         = is_read;
    ack_seen_next        = ack_seen;
    shift_sel            = shift_byte;
    res                  = '0;
    res.scl              = 1'b1;
    res.sda              = 1'b1;
    res.busy_res         = 1'b1;

    case (stage)
      i2cm_pkg::ST_START, i2cm_pkg::ST_RESTART: begin
        res.scl = !phase[1];
        res.sda = (phase == 2'd0);
        if (phase[1]) begin
          shift_byte_next = (stage == i2cm_pkg::ST_START) ? saved_slave : saved_slave_inc;
          stage_next      = (stage == i2cm_pkg::ST_START) ? i2cm_pkg::ST_SLAVE
                                                          : i2cm_pkg::ST_SLAVE_RD;
          phase_next      = 2'd0;
          bit_index_next  = 3'd0;
        end else begin
          phase_next = phase + 2'd1;
        end
      end
      i2cm_pkg::ST_SLAVE, i2cm_pkg::ST_REG, i2cm_pkg::ST_SLAVE_RD,
      i2cm_pkg::ST_DATA: begin
        if (stage == i2cm_pkg::ST_DATA && phase == 2'd0 && bit_index == 3'd0) begin
          shift_sel     = entry.item.wr_data;
          res.take_data = 1'b1;
        end
        res.sda = shift_sel[7];
        res.scl = (phase == 2'd1);
        if (phase[1]) begin
          shift_byte_next = {shift_sel[6:0], 1'b0};
          phase_next      = 2'd0;
          if (bit_index == 3'd7) begin
            bit_index_next = 3'd0;
            case (stage)
              i2cm_pkg::ST_SLAVE:    stage_next = i2cm_pkg::ST_ACK_SLAVE;
              i2cm_pkg::ST_REG:      stage_next = i2cm_pkg::ST_ACK_REG;
              i2cm_pkg::ST_SLAVE_RD: stage_next = i2cm_pkg::ST_ACK_RD;
              default:               stage_next = i2cm_pkg::ST_ACK_DATA;
            endcase
          end else begin
            bit_index_next = bit_index + 3'd1;
          end
        end else begin
          shift_byte_next = shift_sel;
          phase_next      = phase + 2'd1;
        end
      end
      i2cm_pkg::ST_ACK_SLAVE, i2cm_pkg::ST_ACK_REG, i2cm_pkg::ST_ACK_RD,
      i2cm_pkg::ST_ACK_DATA: begin
        res.scl = (phase == 2'd1) || (phase == 2'd2);
        if (phase == 2'd2 && entry.item.sda_in) begin
          ack_seen_next = 1'b1;
        end
        if (phase == 2'd3) begin
          phase_next     = 2'd0;
          bit_index_next = 3'd0;
          // sticky flag: a NACK ignored earlier still aborts once enabled
          if (abort_on_nack && ack_seen) begin
            stage_next = i2cm_pkg::ST_STOP;
          end else begin
            case (stage)
              i2cm_pkg::ST_ACK_SLAVE: begin
                shift_byte_next = saved_reg;
                stage_next      = i2cm_pkg::ST_REG;
              end
              i2cm_pkg::ST_ACK_REG: begin
                stage_next = is_read ? i2cm_pkg::ST_RESTART : i2cm_pkg::ST_DATA;
              end
              i2cm_pkg::ST_ACK_RD: begin
                stage_next = i2cm_pkg::ST_READ;
              end
              default: begin
                bytes_left_next = count_dec;
                stage_next = (count_dec == '0) ? i2cm_pkg::ST_STOP : i2cm_pkg::ST_DATA;
              end
            endcase
          end
        end else begin
          phase_next = phase + 2'd1;
        end
      end
      i2cm_pkg::ST_READ: begin
        if (phase == 2'd0) begin
          res.scl         = 1'b1;
          shift_byte_next = {shift_byte[6:0], entry.item.sda_in};
          phase_next      = 2'd1;
        end else begin
          res.scl    = 1'b0;
          phase_next = 2'd0;
          if (bit_index == 3'd7) begin
            res.rd_data    = shift_byte;
            res.rd_valid   = 1'b1;
            stage_next     = i2cm_pkg::ST_MACK;
            bit_index_next = 3'd0;
          end else begin
            bit_index_next = bit_index + 3'd1;
          end
        end
      end
      i2cm_pkg::ST_MACK: begin
        res.sda = (bytes_left == COUNT_BITS'(1));
        res.scl = (phase == 2'd1);
        if (phase[1]) begin
          bytes_left_next = count_dec;
          stage_next      = (count_dec == '0) ? i2cm_pkg::ST_STOP : i2cm_pkg::ST_READ;
          phase_next      = 2'd0;
          bit_index_next  = 3'd0;
        end else begin
          phase_next = phase + 2'd1;
        end
      end
      i2cm_pkg::ST_STOP: begin
        res.scl = (phase != 2'd0);
        res.sda = phase[1];
        if (phase[1]) begin
          res.done_res   = 1'b1;
          res.nack       = ack_seen;
          stage_next     = i2cm_pkg::ST_IDLE;
          phase_next     = 2'd0;
          bit_index_next = 3'd0;
        end else begin
          phase_next = phase + 2'd1;
        end
      end
      default: begin
        // idle; the command tick is already the first START tick
        stage_next = i2cm_pkg::ST_IDLE;
        if (entry.is_cmd) begin
          is_read_next         = entry.item.opcode;
          saved_slave_next     = entry.item.slave_addr;
          saved_slave_inc_next = entry.slave_inc;
          saved_reg_next       = entry.item.reg_addr;
          bytes_left_next      = COUNT_BITS'(entry.item.byte_count);
          ack_seen_next        = 1'b0;
          stage_next           = i2cm_pkg::ST_START;
          phase_next           = 2'd1;
          bit_index_next       = 3'd0;
        end else begin
          res.busy_res = 1'b0;
          res.scl      = line_levels[1];
          res.sda      = line_levels[0];
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage           <= i2cm_pkg::ST_IDLE;
      phase           <= 2'd0;
      bit_index       <= 3'd0;
      shift_byte      <= 8'd0;
      bytes_left      <= '0;
      saved_slave     <= 8'd0;
      saved_slave_inc <= 8'd0;
      saved_reg       <= 8'd0;
      is_read         <= 1'b0;
      ack_seen        <= 1'b0;
      line_levels     <= 2'b11;
    end else if (pop) begin
      stage           <= stage_next;
      phase           <= phase_next;
      bit_index       <= bit_index_next;
      shift_byte      <= shift_byte_next;
      bytes_left      <= bytes_left_next;
      saved_slave     <= saved_slave_next;
      saved_slave_inc <= saved_slave_inc_next;
      saved_reg       <= saved_reg_next;
      is_read         <= is_read_next;
      ack_seen        <= ack_seen_next;
      line_levels     <= {res.scl, res.sda};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_item <= res;
    end
  end

endmodule

>>> rtl/core/i2c_master_register_access_unit.sv
// A tick accepted at the input is written into a queue slot, and from there into the
// output register when the sequencer pops it.
// One tick per clock is taken unless a full queue or an output stall holds it; the sequencer
// steps its state once per popped queue entry. A two-entry queue sits between the input side
// and the sequencer, the output register after it. Reset (synchronous, active high):
// sequencer idle, queue empty, lines released high, abort_on_nack set to 1.
`include "assert_macros.svh"

module i2c_master_register_access_unit #(
  parameter int COUNT_BITS = 8
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  i2cm_pkg::in_t  in_item,
  output logic           out_valid,
  input  logic           out_stall,
  output i2cm_pkg::out_t out_item,
  input  logic           psel,
  input  logic           penable,
  input  logic           pwrite,
  input  logic [2:0]     paddr,
  input  logic [31:0]    pwdata,
  output logic [31:0]    prdata,
  output logic           pready
);

  i2cm_pkg::entry_t    q_head;
  i2cm_pkg::q_status_t q_status;
  logic                pop;
  logic                abort_on_nack;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == i2cm_pkg::REG_ABORT_ON_NACK) ? {31'd0, abort_on_nack} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      abort_on_nack <= 1'b1;
    end else if (psel && penable && pwrite && pready &&
                 paddr[2] == i2cm_pkg::REG_ABORT_ON_NACK) begin
      abort_on_nack <= pwdata[0];
    end
  end

  // step the sequencer whenever the queue holds an entry and the output slot is free or being drained
  assign pop = q_status.q_valid && (!out_valid || !out_stall);

  i2cm_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .pop      (pop),
    .q_head   (q_head),
    .q_status (q_status)
  );

  i2cm_back #(
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .abort_on_nack (abort_on_nack),
    .pop           (pop),
    .entry         (q_head),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_item      (out_item)
  );

  `ASSERT_IMPL(a_full_has_head, clk, rst, q_status.q_full, q_status.q_valid)
  `ASSERT_NEXT(a_pop_fills_out, clk, rst, pop, out_valid)
  `ASSERT_IMPL(a_done_is_busy, clk, rst, out_valid && out_item.done_res, out_item.busy_res)
  `ASSERT_IMPL(a_take_rd_excl, clk, rst, out_valid, !(out_item.take_data && out_item.rd_valid))

endmodule

>>> dv/i2c_master_register_access_unit_test.sv
`timescale 1ns / 100ps

module i2c_master_register_access_unit_test;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_READ  = 1'b1;
  localparam logic [2:0] ABORT_NACK_ADDR = {i2cm_pkg::REG_ABORT_ON_NACK, 2'b00};
  localparam logic [13:0] ACK_WAITS = i2cm_pkg::ST_ACK_SLAVE | i2cm_pkg::ST_ACK_REG |
                                      i2cm_pkg::ST_ACK_RD | i2cm_pkg::ST_ACK_DATA;
  localparam int TOTAL_TICKS = 1750;
  localparam int LONG_HOLD = 80;
  localparam int CYCLE_LIMIT = 400000;

  logic           clk;
  logic           rst;
  logic           in_valid;
  logic           in_stall;
  i2cm_pkg::in_t  in_item;
  logic           out_valid;
  logic           out_stall;
  i2cm_pkg::out_t out_item;
  logic           psel;
  logic           penable;
  logic           pwrite;
  logic [2:0]     paddr;
  logic [31:0]    pwdata;
  logic [31:0]    prdata;
  logic           pready;

  i2c_master_register_access_unit #(.COUNT_BITS(8)) i_dut (.*);

  // sequencer mirror
  i2cm_pkg::stage_t seq_stage;
  logic [1:0]  seq_phase;
  logic [2:0]  bit_pos;
  logic [7:0]  shifter;
  logic [7:0]  remaining;
  logic [7:0]  slave_byte;
  logic [7:0]  reg_byte;
  logic        rd_mode;
  logic        nack_seen;
  logic [1:0]  last_lines;
  logic        abort_cfg;

  i2cm_pkg::out_t predicted_lines[$];

  // stimulus knobs
  bit          tx_quiet;
  bit          rx_quiet;
  bit          long_hold_req;
  logic [13:0] nack_mask;
  int          nack_pct;

  int mismatches;
  int ticks_sent;
  int busy_ticks;
  int transfers;
  int nack_ends;
  int bytes_read;
  int abort_writes;
  int stalled_cycles;
  int cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("%0t: timeout after %0d cycles", $time, cycles);
    $display("TEST FAILED");
    $finish;
  end

  function automatic void enter_stage(i2cm_pkg::stage_t s);
    seq_stage = s;
    seq_phase = 2'd0;
    bit_pos = 3'd0;
  endfunction

  function automatic void finish_ack_wait();
    if (abort_cfg && nack_seen) begin
      enter_stage(i2cm_pkg::ST_STOP);
    end else begin
      case (seq_stage)
        i2cm_pkg::ST_ACK_SLAVE: begin
          shifter = reg_byte;
          enter_stage(i2cm_pkg::ST_REG);
        end
        i2cm_pkg::ST_ACK_REG: begin
          if (rd_mode) enter_stage(i2cm_pkg::ST_RESTART);
          else enter_stage(i2cm_pkg::ST_DATA);
        end
        i2cm_pkg::ST_ACK_RD: enter_stage(i2cm_pkg::ST_READ);
        default: begin
          remaining = remaining - 8'd1;
          if (remaining == 8'd0) enter_stage(i2cm_pkg::ST_STOP);
          else enter_stage(i2cm_pkg::ST_DATA);
        end
      endcase
    end
  endfunction

  function automatic i2cm_pkg::out_t predict_bus_tick(i2cm_pkg::in_t t);
    i2cm_pkg::out_t o;
    logic scl_v;
    logic sda_v;
    o = '0;
    scl_v = 1'b1;
    sda_v = 1'b1;
    if (seq_stage == i2cm_pkg::ST_IDLE) begin
      if (t.cmd_start) begin
        rd_mode = t.opcode;
        slave_byte = t.slave_addr;
        reg_byte = t.reg_addr;
        remaining = t.byte_count;
        nack_seen = 1'b0;
        enter_stage(i2cm_pkg::ST_START);
      end else begin
        scl_v = last_lines[1];
        sda_v = last_lines[0];
      end
    end
    // the command tick is already the first START tick
    if (seq_stage != i2cm_pkg::ST_IDLE) begin
      o.busy_res = 1'b1;
      case (seq_stage)
        i2cm_pkg::ST_START, i2cm_pkg::ST_RESTART: begin
          scl_v = (seq_phase < 2'd2);
          sda_v = (seq_phase == 2'd0);
          if (seq_phase >= 2'd2) begin
            if (seq_stage == i2cm_pkg::ST_START) begin
              shifter = slave_byte;
              enter_stage(i2cm_pkg::ST_SLAVE);
            end else begin
              shifter = slave_byte + 8'd1;
              enter_stage(i2cm_pkg::ST_SLAVE_RD);
            end
          end else begin
            seq_phase++;
          end
        end
        i2cm_pkg::ST_SLAVE, i2cm_pkg::ST_REG, i2cm_pkg::ST_SLAVE_RD,
        i2cm_pkg::ST_DATA: begin
          if (seq_stage == i2cm_pkg::ST_DATA && seq_phase == 2'd0 && bit_pos == 3'd0) begin
            shifter = t.wr_data;
            o.take_data = 1'b1;
          end
          sda_v = shifter[7];
          scl_v = (seq_phase == 2'd1);
          if (seq_phase >= 2'd2) begin
            shifter = shifter << 1;
            seq_phase = 2'd0;
            if (bit_pos == 3'd7) begin
              // one-hot: the ACK wait follows each byte stage
              seq_stage = i2cm_pkg::stage_t'(seq_stage << 1);
              bit_pos = 3'd0;
            end else begin
              bit_pos++;
            end
          end else begin
            seq_phase++;
          end
        end
        i2cm_pkg::ST_ACK_SLAVE, i2cm_pkg::ST_ACK_REG, i2cm_pkg::ST_ACK_RD,
        i2cm_pkg::ST_ACK_DATA: begin
          sda_v = 1'b1;
          scl_v = (seq_phase == 2'd1 || seq_phase == 2'd2);
          if (seq_phase == 2'd2 && t.sda_in) nack_seen = 1'b1;
          if (seq_phase == 2'd3) finish_ack_wait();
          else seq_phase++;
        end
        i2cm_pkg::ST_READ: begin
          sda_v = 1'b1;
          if (seq_phase == 2'd0) begin
            scl_v = 1'b1;
            shifter = {shifter[6:0], t.sda_in};
            seq_phase = 2'd1;
          end else begin
            scl_v = 1'b0;
            seq_phase = 2'd0;
            if (bit_pos == 3'd7) begin
              o.rd_data = shifter;
              o.rd_valid = 1'b1;
              enter_stage(i2cm_pkg::ST_MACK);
            end else begin
              bit_pos++;
            end
          end
        end
        i2cm_pkg::ST_MACK: begin
          sda_v = (remaining == 8'd1);
          scl_v = (seq_phase == 2'd1);
          if (seq_phase >= 2'd2) begin
            remaining = remaining - 8'd1;
            if (remaining == 8'd0) enter_stage(i2cm_pkg::ST_STOP);
            else enter_stage(i2cm_pkg::ST_READ);
          end else begin
            seq_phase++;
          end
        end
        default: begin
          scl_v = (seq_phase != 2'd0);
          sda_v = (seq_phase >= 2'd2);
          if (seq_phase >= 2'd2) begin
            o.done_res = 1'b1;
            o.nack = nack_seen;
            enter_stage(i2cm_pkg::ST_IDLE);
          end else begin
            seq_phase++;
          end
        end
      endcase
    end
    last_lines = {scl_v, sda_v};
    o.scl = scl_v;
    o.sda = sda_v;
    return o;
  endfunction

  function automatic void reset_predictor();
    abort_cfg = 1'b1;
    enter_stage(i2cm_pkg::ST_IDLE);
    shifter = '0;
    remaining = '0;
    slave_byte = '0;
    reg_byte = '0;
    rd_mode = 1'b0;
    nack_seen = 1'b0;
    last_lines = 2'b11;
  endfunction

  function automatic int pick_gap(bit quiet);
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(6, 16);
  endfunction

  function automatic void compare_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s mismatch: expected 0x%0h, got 0x%0h", $time, name, want, got);
    end
  endfunction

  function automatic void check_bus_tick(i2cm_pkg::out_t got);
    i2cm_pkg::out_t want;
    if (predicted_lines.size() == 0) begin
      mismatches++;
      $display("%0t: unexpected result: expected none, got 0x%0h", $time, got);
      return;
    end
    want = predicted_lines.pop_front();
    compare_field("scl", 8'(want.scl), 8'(got.scl));
    compare_field("sda", 8'(want.sda), 8'(got.sda));
    compare_field("take_data", 8'(want.take_data), 8'(got.take_data));
    compare_field("rd_data", want.rd_data, got.rd_data);
    compare_field("rd_valid", 8'(want.rd_valid), 8'(got.rd_valid));
    compare_field("busy_res", 8'(want.busy_res), 8'(got.busy_res));
    compare_field("done_res", 8'(want.done_res), 8'(got.done_res));
    compare_field("nack", 8'(want.nack), 8'(got.nack));
  endfunction

  // result side: random stalls plus an occasional long hold-off
  initial begin : result_side
    int hold;
    int g;
    out_stall = 1'b0;
    hold = 0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall) check_bus_tick(out_item);
      @(negedge clk);
      if (long_hold_req) begin
        hold = LONG_HOLD;
        long_hold_req = 1'b0;
      end
      if (hold > 0) begin
        out_stall <= 1'b1;
        hold--;
      end else begin
        g = pick_gap(rx_quiet);
        out_stall <= (g > 0);
        if (g > 0) hold = g - 1;
      end
    end
  end

  task automatic send_tick(input i2cm_pkg::in_t t);
    int gap;
    i2cm_pkg::out_t lines;
    gap = pick_gap(tx_quiet);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_item <= t;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) begin
      stalled_cycles++;
      @(posedge clk);
    end
    lines = predict_bus_tick(t);
    predicted_lines.push_back(lines);
    ticks_sent++;
    if (lines.busy_res) busy_ticks++;
    if (lines.done_res) transfers++;
    if (lines.nack) nack_ends++;
    if (lines.rd_valid) bytes_read++;
  endtask

  // random fields; only sda_in during an ACK wait is steered
  function automatic i2cm_pkg::in_t random_tick();
    logic [63:0] r;
    i2cm_pkg::in_t t;
    r = {$urandom(), $urandom()};
    t = r[$bits(i2cm_pkg::in_t)-1:0];
    if ((seq_stage & ACK_WAITS) != 0)
      t.sda_in = ((seq_stage & nack_mask) != 0) || ($urandom_range(0, 99) < nack_pct);
    return t;
  endfunction

  task automatic idle_ticks(input int n);
    i2cm_pkg::in_t t;
    repeat (n) begin
      t = random_tick();
      t.cmd_start = 1'b0;
      send_tick(t);
    end
  endtask

  task automatic start_transfer(input logic op, input logic [7:0] slave,
                                input logic [7:0] regaddr, input logic [7:0] count);
    i2cm_pkg::in_t t;
    t = random_tick();
    t.cmd_start = 1'b1;
    t.opcode = op;
    t.slave_addr = slave;
    t.reg_addr = regaddr;
    t.byte_count = count;
    send_tick(t);
  endtask

  task automatic run_ticks(input i2cm_pkg::stage_t stop_at);
    while (seq_stage != stop_at) send_tick(random_tick());
  endtask

  task automatic transfer(input logic op, input logic [7:0] slave,
                          input logic [7:0] regaddr, input logic [7:0] count);
    start_transfer(op, slave, regaddr, count);
    run_ticks(i2cm_pkg::ST_IDLE);
    idle_ticks($urandom_range(0, 2));
  endtask

  task automatic wait_for_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (predicted_lines.size() != 0) @(posedge clk);
  endtask

  task automatic apb_cycle(input logic wr, input logic [31:0] wdata, output logic [31:0] rdata);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= ABORT_NACK_ADDR;
    pwdata <= wdata;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rdata = prdata;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic check_abort_reg();
    logic [31:0] rd;
    apb_cycle(1'b0, '0, rd);
    if (rd !== {31'b0, abort_cfg}) begin
      mismatches++;
      $display("%0t: abort_on_nack readback: expected 0x%0h, got 0x%0h",
               $time, {31'b0, abort_cfg}, rd);
    end
  endtask

  task automatic set_abort_mode(input logic v);
    logic [31:0] rd;
    wait_for_results();
    apb_cycle(1'b1, {31'b0, v}, rd);
    abort_cfg = v;
    abort_writes++;
    check_abort_reg();
  endtask

  task automatic test_register_reset();
    check_abort_reg();
  endtask

  task automatic test_idle_lines();
    idle_ticks(4);
  endtask

  task automatic test_write_transfer();
    transfer(OP_WRITE, 8'h00, 8'hFF, 8'd1);
    transfer(OP_WRITE, 8'hFF, 8'h00, 8'd2);
  endtask

  task automatic test_read_transfer();
    // slave byte 0xFF wraps to 0x00 after the repeated START
    transfer(OP_READ, 8'hFF, 8'hA5, 8'd1);
    transfer(OP_READ, 8'h50, 8'h00, 8'd3);
  endtask

  task automatic test_nack_abort();
    nack_mask = i2cm_pkg::ST_ACK_SLAVE;
    transfer(OP_WRITE, 8'h3C, 8'h10, 8'd2);
    nack_mask = i2cm_pkg::ST_ACK_DATA;
    transfer(OP_WRITE, 8'h3C, 8'h11, 8'd3);
    nack_mask = i2cm_pkg::ST_ACK_REG;
    transfer(OP_READ, 8'h42, 8'h20, 8'd2);
    nack_mask = i2cm_pkg::ST_ACK_RD;
    transfer(OP_READ, 8'h42, 8'h21, 8'd2);
    nack_mask = '0;
  endtask

  task automatic test_nack_ignored();
    set_abort_mode(1'b0);
    nack_pct = 100;
    transfer(OP_WRITE, 8'h80, 8'h7F, 8'd2);
    nack_pct = 0;
    nack_mask = i2cm_pkg::ST_ACK_RD;
    transfer(OP_READ, 8'h01, 8'hFE, 8'd2);
    // NACK ignored on the slave byte, then abort turned on mid-transaction:
    // the sticky flag must end the next ACK wait in STOP
    nack_mask = i2cm_pkg::ST_ACK_SLAVE;
    start_transfer(OP_WRITE, 8'hA0, 8'h05, 8'd3);
    run_ticks(i2cm_pkg::ST_REG);
    nack_mask = '0;
    set_abort_mode(1'b1);
    run_ticks(i2cm_pkg::ST_IDLE);
    idle_ticks(2);
  endtask

  task automatic test_long_transfers();
    // zero count wraps: the write runs on past the first data bytes until a NACK ends it
    start_transfer(OP_WRITE, 8'h5A, 8'hC3, 8'd0);
    while (remaining != 8'd252) send_tick(random_tick());
    nack_mask = i2cm_pkg::ST_ACK_DATA;
    run_ticks(i2cm_pkg::ST_IDLE);
    nack_mask = '0;
    idle_ticks(1);
    transfer(OP_READ, 8'hA4, 8'h3B, 8'd3);
  endtask

  task automatic test_output_backpressure();
    tx_quiet = 1'b1;
    long_hold_req = 1'b1;
    transfer(OP_READ, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 8'd4);
    tx_quiet = 1'b0;
  endtask

  task automatic test_random_traffic();
    logic [7:0] count;
    do begin
      if ($urandom_range(0, 9) == 0) set_abort_mode(1'($urandom_range(0, 1)));
      tx_quiet = ($urandom_range(0, 5) == 0);
      rx_quiet = ($urandom_range(0, 5) == 0);
      case ($urandom_range(0, 3))
        0, 1: nack_pct = 0;
        2: nack_pct = 4;
        default: nack_pct = 25;
      endcase
      if ($urandom_range(0, 99) < 85) count = 8'($urandom_range(1, 3));
      else count = 8'($urandom_range(4, 12));
      transfer(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
               8'($urandom_range(0, 255)), count);
    end while (ticks_sent < TOTAL_TICKS);
    tx_quiet = 1'b0;
    rx_quiet = 1'b0;
    nack_pct = 0;
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    in_item = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    tx_quiet = 1'b0;
    rx_quiet = 1'b0;
    long_hold_req = 1'b0;
    nack_mask = '0;
    nack_pct = 0;
    mismatches = 0;
    ticks_sent = 0;
    busy_ticks = 0;
    transfers = 0;
    nack_ends = 0;
    bytes_read = 0;
    abort_writes = 0;
    stalled_cycles = 0;
    reset_predictor();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_register_reset();
    test_idle_lines();
    test_write_transfer();
    test_read_transfer();
    test_nack_abort();
    test_nack_ignored();
    test_long_transfers();
    test_output_backpressure();
    test_random_traffic();

    wait_for_results();
    repeat (8) @(posedge clk);
    $display("Run covered %0d ticks (%0d busy) over %0d transfers, %0d bytes read, %0d NACK ends.",
             ticks_sent, busy_ticks, transfers, bytes_read, nack_ends);
    $display("Abort mode rewritten %0d times; input stalled %0d cycles by output hold-off.",
             abort_writes, stalled_cycles);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
